// ----- src/pwsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsd_pkg
// Shared types and constants for the PID controller with settle detection:
// word formats, configuration register set and register indexes.
// ----------------------------------------------------------------------------
package pwsd_pkg;

    // fixed width of error, limit and drive samples
    localparam int ERROR_WIDTH = 16;

    // gain format and integral width defaults
    localparam int GAIN_WIDTH             = 16;
    localparam int GAIN_FRAC_BITS_DEFAULT = 8;
    localparam int INTEGRAL_WIDTH_DEFAULT = 32;

    // configuration port geometry
    localparam int APB_ADDR_WIDTH = 5;
    localparam int APB_DATA_WIDTH = 32;

    // register indexes
    typedef enum logic [2:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_WINDUP_LIMIT = 3'd3,
        REG_EXIT_MODE    = 3'd4,
        REG_ERROR_BAND   = 3'd5,
        REG_SLOPE_BAND   = 3'd6,
        REG_SETTLE_TICKS = 3'd7
    } reg_idx_t;

    // settle rule codes
    localparam logic EXIT_SETTLE_TIME = 1'b0;
    localparam logic EXIT_DERIVATIVE  = 1'b1;

    // input word
    typedef struct packed {
        logic signed [ERROR_WIDTH-1:0] error_in;
        logic signed [ERROR_WIDTH-1:0] limit_low;
        logic signed [ERROR_WIDTH-1:0] limit_high;
    } req_word_t;

    // result word
    typedef struct packed {
        logic signed [ERROR_WIDTH-1:0] drive;
        logic                          is_settled;
    } rsp_word_t;

    // configuration register set
    typedef struct packed {
        logic signed [GAIN_WIDTH-1:0] gain_p;
        logic signed [GAIN_WIDTH-1:0] gain_i;
        logic signed [GAIN_WIDTH-1:0] gain_d;
        logic [14:0]                  windup_limit;
        logic                         exit_mode;
        logic [14:0]                  error_band;
        logic [15:0]                  slope_band;
        logic [15:0]                  settle_ticks;
    } cfg_t;

endpackage

// ----- src/pwsd_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsd_regs
// APB register file holding gains, windup limit and settle rule settings.
// ----------------------------------------------------------------------------
module pwsd_regs
    import pwsd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready,
    output cfg_t                      cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GAIN_P:       cfg_next.gain_p       = pwdata[15:0];
                REG_GAIN_I:       cfg_next.gain_i       = pwdata[15:0];
                REG_GAIN_D:       cfg_next.gain_d       = pwdata[15:0];
                REG_WINDUP_LIMIT: cfg_next.windup_limit = pwdata[14:0];
                REG_EXIT_MODE:    cfg_next.exit_mode    = pwdata[0];
                REG_ERROR_BAND:   cfg_next.error_band   = pwdata[14:0];
                REG_SLOPE_BAND:   cfg_next.slope_band   = pwdata[15:0];
                REG_SETTLE_TICKS: cfg_next.settle_ticks = pwdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p       <= '0;
            cfg_reg.gain_i       <= '0;
            cfg_reg.gain_d       <= '0;
            cfg_reg.windup_limit <= 15'h7FFF;
            cfg_reg.exit_mode    <= EXIT_SETTLE_TIME;
            cfg_reg.error_band   <= '0;
            cfg_reg.slope_band   <= '0;
            cfg_reg.settle_ticks <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back mux
    always_comb
    begin
        case (idx)
            REG_GAIN_P:       prdata = {16'b0, cfg_reg.gain_p};
            REG_GAIN_I:       prdata = {16'b0, cfg_reg.gain_i};
            REG_GAIN_D:       prdata = {16'b0, cfg_reg.gain_d};
            REG_WINDUP_LIMIT: prdata = {17'b0, cfg_reg.windup_limit};
            REG_EXIT_MODE:    prdata = {31'b0, cfg_reg.exit_mode};
            REG_ERROR_BAND:   prdata = {17'b0, cfg_reg.error_band};
            REG_SLOPE_BAND:   prdata = {16'b0, cfg_reg.slope_band};
            REG_SETTLE_TICKS: prdata = {16'b0, cfg_reg.settle_ticks};
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- src/pwsd_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwsd_state
// Controller state: integral with windup and sign-change clearing, previous
// error, first-sample flag and in-band run counter. Produces the updated
// integral, derivative and settled flag for the sample being stepped.
// ----------------------------------------------------------------------------
module pwsd_state
    import pwsd_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cfg_t                             cfg,
    input  logic                             step,
    input  logic signed [ERROR_WIDTH-1:0]    err,
    output logic signed [INTEGRAL_WIDTH-1:0] acc_out,
    output logic signed [ERROR_WIDTH:0]      deriv,
    output logic                             settled
);

    localparam int ACC_SUM_W = INTEGRAL_WIDTH + 1;
    localparam logic signed [ACC_SUM_W-1:0] ACC_MAX =
        ACC_SUM_W'((64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_SUM_W-1:0] ACC_MIN = -ACC_MAX - 1;

    logic signed [ERROR_WIDTH-1:0]    last_error_reg;
    logic signed [INTEGRAL_WIDTH-1:0] acc_reg;
    logic signed [INTEGRAL_WIDTH-1:0] acc_next;
    logic [15:0]                      count_reg;
    logic [15:0]                      count_next;
    logic                             first_reg;

    logic signed [ERROR_WIDTH:0]      err_ext;
    logic [ERROR_WIDTH:0]             mag_err;
    logic [ERROR_WIDTH+1:0]           mag_d;
    logic signed [ACC_SUM_W-1:0]      acc_sum;
    logic                             in_windup;
    logic                             in_band;
    logic                             sign_change;

    // magnitudes
    assign err_ext = (ERROR_WIDTH + 1)'(err);
    assign mag_err = err[ERROR_WIDTH-1] ? (ERROR_WIDTH + 1)'(-err_ext)
                                        : (ERROR_WIDTH + 1)'(err_ext);
    assign in_windup = mag_err <= (ERROR_WIDTH + 1)'(cfg.windup_limit);
    assign in_band   = mag_err <= (ERROR_WIDTH + 1)'(cfg.error_band);

    // derivative, held at zero on the first sample
    assign deriv = first_reg ? '0 : err_ext - (ERROR_WIDTH + 1)'(last_error_reg);
    assign mag_d = deriv[ERROR_WIDTH] ? (ERROR_WIDTH + 2)'(-(ERROR_WIDTH + 2)'(deriv))
                                      : (ERROR_WIDTH + 2)'(deriv);

    // sign of error against sign of previous error
    assign sign_change = (err[ERROR_WIDTH-1] != last_error_reg[ERROR_WIDTH-1])
                      || ((err == '0) != (last_error_reg == '0));

    // integral update with saturation and clearing
    assign acc_sum = ACC_SUM_W'(acc_reg) + ACC_SUM_W'(err);
    always_comb
    begin
        if (!in_windup || sign_change)
            acc_next = '0;
        else if (acc_sum > ACC_MAX)
            acc_next = INTEGRAL_WIDTH'(ACC_MAX);
        else if (acc_sum < ACC_MIN)
            acc_next = INTEGRAL_WIDTH'(ACC_MIN);
        else
            acc_next = INTEGRAL_WIDTH'(acc_sum);
    end
    assign acc_out = acc_next;

    // in-band run counter, only advanced under the settle time rule
    always_comb
    begin
        count_next = count_reg;
        if (cfg.exit_mode == EXIT_SETTLE_TIME)
        begin
            if (!in_band)
                count_next = '0;
            else if (count_reg != 16'hFFFF)
                count_next = count_reg + 16'd1;
        end
    end

    // settled flag per selected rule
    always_comb
    begin
        if (cfg.exit_mode == EXIT_SETTLE_TIME)
            settled = count_next >= cfg.settle_ticks;
        else
            settled = in_band && (mag_d <= (ERROR_WIDTH + 2)'(cfg.slope_band));
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            acc_reg        <= '0;
            count_reg      <= '0;
            first_reg      <= 1'b1;
        end
        else if (step)
        begin
            last_error_reg <= err;
            acc_reg        <= acc_next;
            count_reg      <= count_next;
            first_reg      <= 1'b0;
        end
    end

endmodule

// ----- src/pid_with_settle_detect_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_settle_detect_core
// Fixed-point PID controller with integral windup limit, drive clamping and
// settle detection, fed one error word per cycle unless stalled.
// Throughput: one word per cycle unless stalled; state update is combinational.
// Pipeline: input register, state update, products, sum/saturate/clamp.
// Reset: state and valids cleared, registers to defaults, no clearing pass.
// ----------------------------------------------------------------------------
module pid_with_settle_detect_core
    import pwsd_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT,
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  req_word_t                 req_word,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output rsp_word_t                 rsp_word,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    localparam int DW       = ERROR_WIDTH + 1;
    localparam int P_W      = GAIN_WIDTH + ERROR_WIDTH;
    localparam int I_W      = GAIN_WIDTH + INTEGRAL_WIDTH;
    localparam int D_W      = GAIN_WIDTH + DW;
    localparam int SUM_W    = ((I_W > D_W) ? I_W : D_W) + 2;
    localparam logic signed [SUM_W-1:0] DRV_MAX =
        SUM_W'((64'sd1 <<< (ERROR_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] DRV_MIN = -DRV_MAX - 1;

    cfg_t cfg;

    // handshake
    logic v0_reg, v1_reg, v2_reg, vo_reg;
    logic rdy0, rdy1, rdy2, rdyo;
    logic adv0;

    // stage 0: input register
    req_word_t s0_reg;

    // stage 1: state update results
    logic signed [ERROR_WIDTH-1:0]    s1_err_reg;
    logic signed [DW-1:0]             s1_d_reg;
    logic signed [INTEGRAL_WIDTH-1:0] s1_acc_reg;
    logic signed [ERROR_WIDTH-1:0]    s1_lo_reg;
    logic signed [ERROR_WIDTH-1:0]    s1_hi_reg;
    logic                             s1_set_reg;

    // stage 2: products
    logic signed [P_W-1:0]            s2_p_reg;
    logic signed [I_W-1:0]            s2_i_reg;
    logic signed [D_W-1:0]            s2_d_reg;
    logic signed [ERROR_WIDTH-1:0]    s2_lo_reg;
    logic signed [ERROR_WIDTH-1:0]    s2_hi_reg;
    logic                             s2_set_reg;

    // output register
    rsp_word_t out_reg;
    rsp_word_t out_next;

    logic signed [INTEGRAL_WIDTH-1:0] acc_new;
    logic signed [DW-1:0]             deriv;
    logic                             settled;
    logic signed [SUM_W-1:0]          sum;
    logic signed [SUM_W-1:0]          scaled;
    logic signed [ERROR_WIDTH-1:0]    sat_drive;

    // configuration registers
    pwsd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // pipeline flow control
    assign rdyo      = !vo_reg || !rsp_stall;
    assign rdy2      = !v2_reg || rdyo;
    assign rdy1      = !v1_reg || rdy2;
    assign rdy0      = !v0_reg || rdy1;
    assign adv0      = v0_reg && rdy1;
    assign req_stall = !rdy0;
    assign rsp_valid = vo_reg;
    assign rsp_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= req_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdyo)
                vo_reg <= v2_reg;
        end
    end

    // controller state
    pwsd_state #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step    (adv0),
        .err     (s0_reg.error_in),
        .acc_out (acc_new),
        .deriv   (deriv),
        .settled (settled)
    );

    // final sum, floor scaling, saturation and clamp
    assign sum    = SUM_W'(s2_p_reg) + SUM_W'(s2_i_reg) + SUM_W'(s2_d_reg);
    assign scaled = sum >>> GAIN_FRAC_BITS;

    always_comb
    begin
        if (scaled > DRV_MAX)
            sat_drive = ERROR_WIDTH'(DRV_MAX);
        else if (scaled < DRV_MIN)
            sat_drive = ERROR_WIDTH'(DRV_MIN);
        else
            sat_drive = ERROR_WIDTH'(scaled);

        out_next.is_settled = s2_set_reg;
        if (sat_drive < s2_lo_reg)
            out_next.drive = s2_lo_reg;
        else if (sat_drive > s2_hi_reg)
            out_next.drive = s2_hi_reg;
        else
            out_next.drive = sat_drive;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy0 && req_valid)
            s0_reg <= req_word;
        if (adv0)
        begin
            s1_err_reg <= s0_reg.error_in;
            s1_d_reg   <= deriv;
            s1_acc_reg <= acc_new;
            s1_lo_reg  <= s0_reg.limit_low;
            s1_hi_reg  <= s0_reg.limit_high;
            s1_set_reg <= settled;
        end
        if (rdy2 && v1_reg)
        begin
            s2_p_reg   <= cfg.gain_p * s1_err_reg;
            s2_i_reg   <= cfg.gain_i * s1_acc_reg;
            s2_d_reg   <= cfg.gain_d * s1_d_reg;
            s2_lo_reg  <= s1_lo_reg;
            s2_hi_reg  <= s1_hi_reg;
            s2_set_reg <= s1_set_reg;
        end
        if (rdyo && v2_reg)
            out_reg <= out_next;
    end

endmodule

// ----- sim/tb_pid_with_settle_detect_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_with_settle_detect_core
// Self-checking bench for the PID core. Error words stream through the
// valid/stall channels with random gaps and back-pressure, gains and settle
// rules are reprogrammed over APB between phases, and every result word is
// checked in order against the controller model or a directed table entry.
// ----------------------------------------------------------------------------
module tb_pid_with_settle_detect_core;
    import pwsd_pkg::*;

    localparam int FRAC_BITS    = GAIN_FRAC_BITS_DEFAULT;
    localparam int ACC_WIDTH    = INTEGRAL_WIDTH_DEFAULT;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;
    localparam int SAT_RUN      = 20;

    localparam logic signed [15:0] S_MIN = 16'sh8000;
    localparam logic signed [15:0] S_MAX = 16'sh7FFF;

    // one row of the directed table
    typedef struct {
        req_word_t word;
        bit        typed;
        rsp_word_t want;
    } row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    req_word_t                 req_word = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    rsp_word_t                 rsp_word;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata = '0;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;

    // controller model state and register copy
    cfg_t                          ctl;
    logic signed [ACC_WIDTH-1:0]   acc_model;
    logic signed [ERROR_WIDTH-1:0] prev_err;
    logic [15:0]                   band_run;
    logic                          fresh;

    rsp_word_t drive_q[$];
    row_t      dir_rows[$];
    int        n_in = 0;
    int        n_out = 0;
    int        n_bad = 0;
    int        quiet_cycles = 0;
    int        stall_left = 0;
    int        trace_err = 0;
    bit        idle_on = 1'b1;

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pid_with_settle_detect_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // expected drive and settle flag for one sample, advances the model state
    function automatic rsp_word_t next_drive(input req_word_t w);
        longint    err, prev, lo, hi, slope, acc, sum, mag_e, mag_d, acc_hi, acc_lo;
        rsp_word_t r;
        err    = longint'($signed(w.error_in));
        lo     = longint'($signed(w.limit_low));
        hi     = longint'($signed(w.limit_high));
        prev   = longint'(prev_err);
        acc_hi = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
        acc_lo = -acc_hi - 1;
        mag_e  = (err < 0) ? -err : err;

        // integral: saturating sum inside the windup limit, cleared outside
        if (mag_e <= longint'(ctl.windup_limit))
        begin
            acc = longint'(acc_model) + err;
            if (acc > acc_hi)
                acc = acc_hi;
            else if (acc < acc_lo)
                acc = acc_lo;
        end
        else
            acc = 0;

        // sign change (including to or from zero) clears the integral
        if (((err > 0) != (prev > 0)) || ((err < 0) != (prev < 0)))
            acc = 0;

        // derivative is zero on the first sample after reset
        slope = fresh ? 0 : err - prev;
        mag_d = (slope < 0) ? -slope : slope;

        // settle rules
        if (ctl.exit_mode == EXIT_SETTLE_TIME)
        begin
            if (mag_e <= longint'(ctl.error_band))
                band_run = (band_run == 16'hFFFF) ? band_run : band_run + 16'd1;
            else
                band_run = '0;
            r.is_settled = (band_run >= ctl.settle_ticks);
        end
        else
            r.is_settled = (mag_e <= longint'(ctl.error_band)) &&
                           (mag_d <= longint'(ctl.slope_band));

        // weighted sum, floor shift, saturate, then clamp low first
        sum = longint'($signed(ctl.gain_p)) * err + longint'($signed(ctl.gain_i)) * acc +
              longint'($signed(ctl.gain_d)) * slope;
        sum = sum >>> FRAC_BITS;
        if (sum > 32767)
            sum = 32767;
        else if (sum < -32768)
            sum = -32768;
        if (sum < lo)
            sum = lo;
        else if (sum > hi)
            sum = hi;
        r.drive = sum[ERROR_WIDTH-1:0];

        acc_model = acc[ACC_WIDTH-1:0];
        prev_err  = w.error_in;
        fresh     = 1'b0;
        return r;
    endfunction

    // apb write, setup then access; bus left selected for back-to-back writes
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_WIDTH-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_GAIN_P:       ctl.gain_p       = val[15:0];
            REG_GAIN_I:       ctl.gain_i       = val[15:0];
            REG_GAIN_D:       ctl.gain_d       = val[15:0];
            REG_WINDUP_LIMIT: ctl.windup_limit = val[14:0];
            REG_EXIT_MODE:    ctl.exit_mode    = val[0];
            REG_ERROR_BAND:   ctl.error_band   = val[14:0];
            REG_SLOPE_BAND:   ctl.slope_band   = val[15:0];
            REG_SETTLE_TICKS: ctl.settle_ticks = val[15:0];
            default:          ;
        endcase
    endtask

    // program the full register set, then release the bus
    task automatic load_regs(input cfg_t c);
        write_reg(REG_GAIN_P, 32'(c.gain_p));
        write_reg(REG_GAIN_I, 32'(c.gain_i));
        write_reg(REG_GAIN_D, 32'(c.gain_d));
        write_reg(REG_WINDUP_LIMIT, 32'(c.windup_limit));
        write_reg(REG_EXIT_MODE, 32'(c.exit_mode));
        write_reg(REG_ERROR_BAND, 32'(c.error_band));
        write_reg(REG_SLOPE_BAND, 32'(c.slope_band));
        write_reg(REG_SETTLE_TICKS, 32'(c.settle_ticks));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // random register set, mostly moderate values so settling is reachable
    function automatic cfg_t draw_config();
        cfg_t c;
        c.gain_p       = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                         : 16'($urandom_range(0, 1024)) - 16'd512;
        c.gain_i       = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                         : 16'($urandom_range(0, 128)) - 16'd64;
        c.gain_d       = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                         : 16'($urandom_range(0, 1024)) - 16'd512;
        c.windup_limit = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                         : 15'($urandom_range(0, 3000));
        c.exit_mode    = $urandom_range(0, 1) ? EXIT_DERIVATIVE : EXIT_SETTLE_TIME;
        c.error_band   = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                         : 15'($urandom_range(0, 200));
        c.slope_band   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                         : 16'($urandom_range(0, 400));
        c.settle_ticks = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                         : 16'($urandom_range(0, 10));
        return c;
    endfunction

    // offer one word, with an optional gap first; predict at acceptance
    task automatic send_word(input req_word_t w, input bit typed, input rsp_word_t want);
        rsp_word_t pred;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pred = next_drive(w);
        drive_q.push_back(typed ? want : pred);
        n_in++;
    endtask

    // drop valid and wait until every result is back
    task automatic quiesce();
        req_valid <= 1'b0;
        @(posedge clk);
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    function automatic void add_row(input int e, input int lo, input int hi,
                                    input bit typed = 1'b0, input int drv = 0,
                                    input bit settled = 1'b0);
        row_t r;
        r.word.error_in    = e[15:0];
        r.word.limit_low   = lo[15:0];
        r.word.limit_high  = hi[15:0];
        r.typed            = typed;
        r.want.drive       = drv[15:0];
        r.want.is_settled  = settled;
        dir_rows.push_back(r);
    endfunction

    // random words: mostly decaying error trajectories, plus in-band, noise, extremes
    task automatic run_random(input int count, input bit allow_idle);
        req_word_t w;
        int        e, a, b, reach;
        for (int k = 0; k < count; k++)
        begin
            if (allow_idle && $urandom_range(0, 63) == 0)
                idle_on = !idle_on;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    if (trace_err == 0 || $urandom_range(0, 23) == 0)
                        trace_err = int'($urandom_range(0, 65535)) - 32768;
                    else
                        trace_err = (trace_err * 3) / 4 + int'($urandom_range(0, 6)) - 3;
                    if (trace_err > 32767)
                        trace_err = 32767;
                    else if (trace_err < -32768)
                        trace_err = -32768;
                    e = trace_err;
                end
                6, 7:
                begin
                    reach = int'(ctl.error_band) + 2;
                    e = int'($urandom_range(0, 2 * reach)) - reach;
                    if (e > 32767)
                        e = 32767;
                    else if (e < -32768)
                        e = -32768;
                end
                8:
                    e = int'($urandom_range(0, 65535)) - 32768;
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       e = -32768;
                        1:       e = 32767;
                        2:       e = 0;
                        3:       e = 1;
                        default: e = -1;
                    endcase
                end
            endcase
            a = int'($urandom_range(0, 65535)) - 32768;
            b = int'($urandom_range(0, 65535)) - 32768;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    a = -32768;
                    b = 32767;
                end
                7, 8:
                begin
                    if (a > b)
                    begin
                        reach = a;
                        a = b;
                        b = reach;
                    end
                end
                default: ;
            endcase
            w.error_in   = e[15:0];
            w.limit_low  = a[15:0];
            w.limit_high = b[15:0];
            send_word(w, 1'b0, '0);
        end
    endtask

    // result checker and receive-side back-pressure
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            n_out++;
            if (drive_q.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("unexpected result word: drive %0d settled %0b",
                             $signed(rsp_word.drive), rsp_word.is_settled);
            end
            else
            begin
                want = drive_q.pop_front();
                if (rsp_word.drive !== want.drive || rsp_word.is_settled !== want.is_settled)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("result %0d: drive exp %0d got %0d, settled exp %0b got %0b",
                                 n_out, $signed(want.drive), $signed(rsp_word.drive),
                                 want.is_settled, rsp_word.is_settled);
                end
            end
        end
        if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(0, 5);
        end
        else
            rsp_stall <= 1'b0;
    end

    // watchdog on cycles where no word moves
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // main sequence
    initial
    begin
        cfg_t      plan;
        req_word_t w;

        // model starts from the reset values
        ctl = '{gain_p: '0, gain_i: '0, gain_d: '0, windup_limit: 15'h7FFF,
                exit_mode: EXIT_SETTLE_TIME, error_band: '0, slope_band: '0,
                settle_ticks: 16'd1};
        acc_model = '0;
        prev_err  = '0;
        band_run  = '0;
        fresh     = 1'b1;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unity integral and derivative gains, everything else at reset
        plan        = ctl;
        plan.gain_i = 16'sd256;
        plan.gain_d = 16'sd256;
        load_regs(plan);

        // first sample: no derivative, integral cleared by the sign rule
        add_row(1000, -32768, 32767, 1'b1, 0, 1'b0);
        add_row(1000, -32768, 32767);
        add_row(-1000, -32768, 32767);
        add_row(0, -100, 100);
        add_row(0, 0, 0, 1'b1, 0, 1'b1);
        add_row(32767, -32768, 32767);
        add_row(32767, -32768, 32767);
        // magnitude above the windup limit, drive saturates
        add_row(-32768, -32768, 32767);
        add_row(-32768, 5, 5, 1'b1, 5, 1'b0);
        add_row(-1, -32768, 32767);
        add_row(-1, 200, 300);
        // crossed limits
        add_row(-1, 300, 200);
        add_row(5, 300, -300);
        add_row(0, 32767, 32767, 1'b1, 32767, 1'b1);
        add_row(0, -32768, -32768, 1'b1, -32768, 1'b1);
        add_row(12345, -32768, 32767);
        add_row(-12345, -32768, 32767);
        add_row(32767, 10, -10);
        add_row(-32768, -32768, -32768, 1'b1, -32768, 1'b0);
        add_row(7, 32767, -32768);
        foreach (dir_rows[k])
            send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].want);
        quiesce();

        // moderate settings, settle-time rule
        plan = '{gain_p: 16'sd256, gain_i: 16'sd16, gain_d: 16'sd64, windup_limit: 15'd2000,
                 exit_mode: EXIT_SETTLE_TIME, error_band: 15'd50, slope_band: 16'd100,
                 settle_ticks: 16'd3};
        load_regs(plan);
        run_random(300, 1'b1);
        quiesce();

        // low extremes: windup and bands closed, zero settle ticks
        plan = '{gain_p: S_MIN, gain_i: S_MAX, gain_d: S_MIN, windup_limit: 15'd0,
                 exit_mode: EXIT_SETTLE_TIME, error_band: 15'd0, slope_band: 16'd0,
                 settle_ticks: 16'd0};
        load_regs(plan);
        run_random(250, 1'b1);
        quiesce();

        // high extremes, derivative rule
        plan = '{gain_p: S_MAX, gain_i: S_MIN, gain_d: S_MAX, windup_limit: 15'h7FFF,
                 exit_mode: EXIT_DERIVATIVE, error_band: 15'h7FFF, slope_band: 16'hFFFF,
                 settle_ticks: 16'hFFFF};
        load_regs(plan);
        run_random(250, 1'b1);
        quiesce();

        repeat (3)
        begin
            load_regs(draw_config());
            run_random(250, 1'b1);
            quiesce();
        end

        // constant runs at full scale: integral builds up, in-band count climbs
        plan = '{gain_p: '0, gain_i: 16'sd1, gain_d: '0, windup_limit: 15'h7FFF,
                 exit_mode: EXIT_SETTLE_TIME, error_band: 15'h7FFF, slope_band: '0,
                 settle_ticks: 16'hFFFF};
        load_regs(plan);
        w = '{error_in: S_MAX, limit_low: S_MIN, limit_high: S_MAX};
        repeat (SAT_RUN)
            send_word(w, 1'b0, '0);
        w.error_in = -16'sd32767;
        repeat (SAT_RUN)
            send_word(w, 1'b0, '0);
        quiesce();

        // closing stretch at full rate, no gaps and no back-pressure
        idle_on = 1'b0;
        load_regs(draw_config());
        run_random(300, 1'b0);
        quiesce();

        $display("ran %0d sample words and %0d result words over nine register settings,",
                 n_in, n_out);
        $display("both settle rules, limit clamps and full-scale constant error runs");
        if (n_bad == 0 && drive_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- pid_with_settle_detect_core.f -----
src/pwsd_pkg.sv
src/pwsd_regs.sv
src/pwsd_state.sv
src/pid_with_settle_detect_core.sv
sim/tb_pid_with_settle_detect_core.sv
